### rtl/lsmid_pkg.sv
// Shared constants and types for the lattice site distance pipeline.
`timescale 1ns / 1ps
`default_nettype none

package lsmid_pkg;

    // Field widths of the stream items
    localparam int IDX_W  = 18;
    localparam int DIST_W = 26;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Configuration register indexes
    localparam logic [2:0] REG_KIND  = 3'd0;
    localparam logic [2:0] REG_LEN_A = 3'd1;
    localparam logic [2:0] REG_LEN_B = 3'd2;
    localparam logic [2:0] REG_SIDE  = 3'd3;
    localparam logic [2:0] REG_WRAP  = 3'd4;

    // Crystal kinds
    localparam logic [2:0] KIND_RECT   = 3'd0;
    localparam logic [2:0] KIND_CRECT  = 3'd1;
    localparam logic [2:0] KIND_TRI    = 3'd2;
    localparam logic [2:0] KIND_HONEY  = 3'd3;
    localparam logic [2:0] KIND_KAGOME = 3'd4;
    localparam logic [2:0] KIND_LIEB   = 3'd5;

    // Q0.16 scale factors: sqrt3/2, sqrt3/6, sqrt3/4
    localparam logic [15:0] K_SQRT3_2 = 16'd56756;
    localparam logic [15:0] K_SQRT3_6 = 16'd18919;
    localparam logic [15:0] K_SQRT3_4 = 16'd28378;

    // ceil(2^19 / 3): exact divide by three for 18-bit indexes
    localparam logic [17:0] DIV3_MUL = 18'd174763;

    // Stage flow control handed to the pipelined units
    typedef struct packed {
        logic en;
        logic vld;
    } t_flow;

endpackage

`default_nettype wire

### rtl/lattice_site_min_image_distance.sv
// Top level: minimum-image distance between two atoms of a 2D lattice patch.
`timescale 1ns / 1ps
`default_nettype none

// Takes a pair of atom indices per transfer and returns their distance in
// unsigned Q14.12, one pair per clock while the skid register is empty. The
// row/column divider and the square root each resolve one bit per stage;
// the square root pipeline has a root width of SIDE_W + 21 bits. Stalls on
// the output are absorbed by a skid register, so a full pipeline keeps
// accepting until both output registers hold results. Index faults return
// distance zero with the fault flag in tuser. Configuration writes must
// only occur while no pair is in flight.
module lattice_site_min_image_distance #(
    parameter int MAX_SIDE_CELLS = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [39:0] i_s_tdata,   // [17:0] first_atom, [35:18] second_atom
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // [25:0] distance
    output logic             o_m_tuser,   // [0] index_fault
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_wdata
);

    localparam int IW     = lsmid_pkg::IDX_W;
    localparam int DW     = lsmid_pkg::DIST_W;
    localparam int SIDE_W = $clog2(MAX_SIDE_CELLS + 1);
    localparam int CW     = (MAX_SIDE_CELLS > 1) ? $clog2(MAX_SIDE_CELLS) : 1;
    localparam int SCW    = (SIDE_W > 9) ? SIDE_W : 9;
    localparam int CNTW   = 2 * SIDE_W + 2;
    localparam int CMW    = (CNTW > IW) ? CNTW : IW;
    localparam int XW     = SIDE_W + 19;
    localparam int LW     = SIDE_W + 18;
    localparam int MW     = SIDE_W + 20;
    localparam int QW     = 2 * MW + 1;
    localparam int OW     = (QW + 1) / 2;
    localparam int RW     = OW - 1;
    localparam int EW     = (RW > DW) ? RW : DW;

    // ---------------- configuration ----------------
    logic [2:0]  r_kind;
    logic [15:0] r_len_a;
    logic [15:0] r_len_b;
    logic [8:0]  r_side;
    logic        r_wrap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= lsmid_pkg::KIND_RECT;
            r_len_a <= 16'd4096;
            r_len_b <= 16'd4096;
            r_side  <= 9'd16;
            r_wrap  <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lsmid_pkg::REG_KIND:  r_kind  <= i_cfg_wdata[2:0];
                lsmid_pkg::REG_LEN_A: r_len_a <= i_cfg_wdata;
                lsmid_pkg::REG_LEN_B: r_len_b <= i_cfg_wdata;
                lsmid_pkg::REG_SIDE:  r_side  <= i_cfg_wdata[8:0];
                lsmid_pkg::REG_WRAP:  r_wrap  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // b * K rounded half up to the internal unit (fraction bits + 2)
    function automatic logic [17:0] scale_b(input logic [15:0] b, input logic [15:0] k);
        logic [32:0] p;
        p = 33'(b) * 33'(k) + 33'd8192;
        return p[31:14];
    endfunction

    logic [17:0]       a_ext, b_ext, t1x, t1y;
    logic [17:0]       bx [3];
    logic [17:0]       by [3];
    logic [1:0]        nsite;
    logic [SIDE_W-1:0] side;
    logic [SCW-1:0]    side_ext;
    logic [CNTW-1:0]   side_sq, count;

    always_comb begin
        a_ext    = {r_len_a, 2'b00};
        b_ext    = {r_len_b, 2'b00};
        nsite    = 2'd1;
        t1x      = '0;
        t1y      = b_ext;
        bx[0]    = '0;
        bx[1]    = '0;
        bx[2]    = '0;
        by[0]    = '0;
        by[1]    = '0;
        by[2]    = '0;
        case (r_kind)
            lsmid_pkg::KIND_RECT: ;
            lsmid_pkg::KIND_CRECT: begin
                nsite = 2'd2;
                bx[1] = a_ext >> 1;
                by[1] = b_ext >> 1;
            end
            lsmid_pkg::KIND_TRI: begin
                t1x = a_ext >> 1;
                t1y = scale_b(r_len_b, lsmid_pkg::K_SQRT3_2);
            end
            lsmid_pkg::KIND_HONEY: begin
                nsite = 2'd2;
                t1x   = a_ext >> 1;
                t1y   = scale_b(r_len_b, lsmid_pkg::K_SQRT3_2);
                bx[1] = a_ext >> 1;
                by[1] = scale_b(r_len_b, lsmid_pkg::K_SQRT3_6);
            end
            lsmid_pkg::KIND_KAGOME: begin
                nsite = 2'd3;
                t1x   = a_ext >> 1;
                t1y   = scale_b(r_len_b, lsmid_pkg::K_SQRT3_2);
                bx[1] = a_ext >> 1;
                bx[2] = a_ext >> 2;
                by[2] = scale_b(r_len_b, lsmid_pkg::K_SQRT3_4);
            end
            lsmid_pkg::KIND_LIEB: begin
                nsite = 2'd3;
                bx[1] = a_ext >> 1;
                by[2] = b_ext >> 1;
            end
            default: ;  // unused kinds behave as rectangular
        endcase

        side_ext = SCW'(r_side);
        side     = (side_ext > SCW'(MAX_SIDE_CELLS)) ? SIDE_W'(MAX_SIDE_CELLS)
                                                     : SIDE_W'(side_ext);
        side_sq  = CNTW'(side) * CNTW'(side);
        case (nsite)
            2'd2:    count = side_sq << 1;
            2'd3:    count = side_sq + (side_sq << 1);
            default: count = side_sq;
        endcase
    end

    // index -> {site, cell}
    function automatic logic [IW+1:0] split_idx(input logic [IW-1:0] idx,
                                                input logic [1:0] ns);
        logic [36:0]   p;
        logic [IW-1:0] q;
        logic [IW-1:0] r3;
        logic [IW+1:0] res;
        p  = 37'(idx) * 37'(lsmid_pkg::DIV3_MUL);
        q  = p[36:19];
        r3 = idx - IW'(20'(q) * 20'd3);
        case (ns)
            2'd2:    res = {1'b0, idx[0], 1'b0, idx[IW-1:1]};
            2'd3:    res = {r3[1:0], q};
            default: res = {2'b00, idx};
        endcase
        return res;
    endfunction

    // ---------------- flow control ----------------
    logic             en;
    lsmid_pkg::t_flow div_flow, sqrt_flow;
    logic             r_skid_v;

    assign en         = !r_skid_v;
    assign o_s_tready = en;

    // ---------------- S1: input register ----------------
    logic          r_v1;
    logic [IW-1:0] r_ia, r_ib;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ia <= i_s_tdata[IW-1:0];
            r_ib <= i_s_tdata[2*IW-1:IW];
        end
    end

    // ---------------- S2: fault check, site split ----------------
    logic          r_v2, r_fault;
    logic [IW-1:0] r_cell_a, r_cell_b;
    logic [1:0]    r_site_a, r_site_b;
    logic [IW+1:0] sp_a, sp_b;
    logic          fault;

    assign sp_a  = split_idx(r_ia, nsite);
    assign sp_b  = split_idx(r_ib, nsite);
    assign fault = (CMW'(r_ia) >= CMW'(count)) || (CMW'(r_ib) >= CMW'(count));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fault  <= fault;
            r_cell_a <= sp_a[IW-1:0];
            r_site_a <= sp_a[IW+1:IW];
            r_cell_b <= sp_b[IW-1:0];
            r_site_b <= sp_b[IW+1:IW];
        end
    end

    // ---------------- column / row split ----------------
    logic          dva_vld, dvb_vld;
    logic [CW-1:0] row_a, row_b;
    logic [IW-1:0] rem_a, rem_b;
    logic [2:0]    dpay_a;
    logic [1:0]    dpay_b;

    assign div_flow = '{en: en, vld: r_v2};

    lsmid_div #(.NW(IW), .DVW(SIDE_W), .QBW(CW), .PW(3)) u_div_a (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_flow     (div_flow),
        .i_dividend (r_cell_a),
        .i_divisor  (side),
        .i_pay      ({r_fault, r_site_a}),
        .o_vld      (dva_vld),
        .o_quo      (row_a),
        .o_rem      (rem_a),
        .o_pay      (dpay_a)
    );

    lsmid_div #(.NW(IW), .DVW(SIDE_W), .QBW(CW), .PW(2)) u_div_b (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_flow     (div_flow),
        .i_dividend (r_cell_b),
        .i_divisor  (side),
        .i_pay      (r_site_b),
        .o_vld      (dvb_vld),
        .o_quo      (row_b),
        .o_rem      (rem_b),
        .o_pay      (dpay_b)
    );

    // ---------------- P1..P7 valid / fault line ----------------
    logic r_vp [7];
    logic r_fp [7];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 7; k++) r_vp[k] <= 1'b0;
        end else if (en) begin
            r_vp[0] <= dva_vld;
            for (int k = 1; k < 7; k++) r_vp[k] <= r_vp[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fp[0] <= dpay_a[2];
            for (int k = 1; k < 7; k++) r_fp[k] <= r_fp[k-1];
        end
    end

    // ---------------- P1: coordinates ----------------
    logic [XW-1:0] r_xa, r_ya, r_xb, r_yb;
    logic [17:0]   bxa, bya, bxb, byb;

    assign bxa = (dpay_a[1:0] == 2'd3) ? '0 : bx[dpay_a[1:0]];
    assign bya = (dpay_a[1:0] == 2'd3) ? '0 : by[dpay_a[1:0]];
    assign bxb = (dpay_b == 2'd3) ? '0 : bx[dpay_b];
    assign byb = (dpay_b == 2'd3) ? '0 : by[dpay_b];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_xa <= XW'(rem_a[CW-1:0]) * XW'(a_ext) + XW'(row_a) * XW'(t1x) + XW'(bxa);
            r_ya <= XW'(row_a) * XW'(t1y) + XW'(bya);
            r_xb <= XW'(rem_b[CW-1:0]) * XW'(a_ext) + XW'(row_b) * XW'(t1x) + XW'(bxb);
            r_yb <= XW'(row_b) * XW'(t1y) + XW'(byb);
        end
    end

    // ---------------- P2: difference, patch shifts ----------------
    logic signed [XW:0] r_dx, r_dy;
    logic [LW-1:0]      r_la, r_lt1x, r_lt1y;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx   <= $signed({1'b0, r_xb}) - $signed({1'b0, r_xa});
            r_dy   <= $signed({1'b0, r_yb}) - $signed({1'b0, r_ya});
            r_la   <= LW'(side) * LW'(a_ext);
            r_lt1x <= LW'(side) * LW'(t1x);
            r_lt1y <= LW'(side) * LW'(t1y);
        end
    end

    // ---------------- P3: nine images, magnitudes ----------------
    logic signed [MW:0] off_n [3];
    logic signed [MW:0] off_mx [3];
    logic signed [MW:0] off_my [3];
    logic signed [MW:0] sx [9];
    logic signed [MW:0] sy [9];
    logic [MW-1:0]      r_ax [9];
    logic [MW-1:0]      r_ay [9];

    always_comb begin
        off_n[0]  = -$signed((MW+1)'(r_la));
        off_n[1]  = '0;
        off_n[2]  = $signed((MW+1)'(r_la));
        off_mx[0] = -$signed((MW+1)'(r_lt1x));
        off_mx[1] = '0;
        off_mx[2] = $signed((MW+1)'(r_lt1x));
        off_my[0] = -$signed((MW+1)'(r_lt1y));
        off_my[1] = '0;
        off_my[2] = $signed((MW+1)'(r_lt1y));
        for (int n = 0; n < 3; n++) begin
            for (int m = 0; m < 3; m++) begin
                sx[3*n+m] = (MW+1)'(r_dx) + off_n[n] + off_mx[m];
                sy[3*n+m] = (MW+1)'(r_dy) + off_my[m];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 9; j++) begin
                r_ax[j] <= sx[j][MW] ? MW'(-sx[j]) : MW'(sx[j]);
                r_ay[j] <= sy[j][MW] ? MW'(-sy[j]) : MW'(sy[j]);
            end
        end
    end

    // ---------------- P4: squares ----------------
    logic [2*MW-1:0] r_sqx [9];
    logic [2*MW-1:0] r_sqy [9];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 9; j++) begin
                r_sqx[j] <= (2*MW)'(r_ax[j]) * (2*MW)'(r_ax[j]);
                r_sqy[j] <= (2*MW)'(r_ay[j]) * (2*MW)'(r_ay[j]);
            end
        end
    end

    // ---------------- P5: squared lengths ----------------
    logic [QW-1:0] r_q [9];

    // with hard edges only the unshifted image (center, index 4) counts
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < 9; j++) begin
                r_q[j] <= (!r_wrap && j != 4) ? {QW{1'b1}}
                                              : QW'(r_sqx[j]) + QW'(r_sqy[j]);
            end
        end
    end

    // ---------------- P6 / P7: minimum tree ----------------
    logic [QW-1:0] r_m3 [3];
    logic [QW-1:0] r_best;
    logic [QW-1:0] m2 [3];
    logic [QW-1:0] b2;

    always_comb begin
        for (int g = 0; g < 3; g++) begin
            m2[g] = (r_q[3*g+1] < r_q[3*g]) ? r_q[3*g+1] : r_q[3*g];
            m2[g] = (r_q[3*g+2] < m2[g]) ? r_q[3*g+2] : m2[g];
        end
        b2 = (r_m3[1] < r_m3[0]) ? r_m3[1] : r_m3[0];
        b2 = (r_m3[2] < b2) ? r_m3[2] : b2;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int g = 0; g < 3; g++) r_m3[g] <= m2[g];
            r_best <= b2;
        end
    end

    // ---------------- square root ----------------
    logic          sq_vld;
    logic [OW-1:0] root;
    logic          sq_fault;

    assign sqrt_flow = '{en: en, vld: r_vp[6]};

    lsmid_sqrt #(.IW(QW), .OW(OW), .PW(1)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flow  (sqrt_flow),
        .i_rad   (r_best),
        .i_pay   (r_fp[6]),
        .o_vld   (sq_vld),
        .o_root  (root),
        .o_pay   (sq_fault)
    );

    // ---------------- rounding, saturation ----------------
    logic [OW:0]   rsum;
    logic [EW-1:0] rnd;
    logic [DW-1:0] sat_dist;

    always_comb begin
        rsum = (OW+1)'(root) + (OW+1)'(2);
        rnd  = EW'(rsum[OW:2]);
        if (sq_fault) begin
            sat_dist = '0;
        end else if (rnd > EW'(lsmid_pkg::DIST_MAX)) begin
            sat_dist = lsmid_pkg::DIST_MAX;
        end else begin
            sat_dist = rnd[DW-1:0];
        end
    end

    // ---------------- output register + skid ----------------
    logic          r_out_v;
    logic [DW-1:0] r_out_d, r_skid_d;
    logic          r_out_f, r_skid_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (i_m_tready) begin
                r_skid_v <= 1'b0;
            end
        end else if (!r_out_v || i_m_tready) begin
            r_out_v <= sq_vld;
        end else if (sq_vld) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (i_m_tready) begin
                r_out_d <= r_skid_d;
                r_out_f <= r_skid_f;
            end
        end else if (!r_out_v || i_m_tready) begin
            r_out_d <= sat_dist;
            r_out_f <= sq_fault;
        end else begin
            r_skid_d <= sat_dist;
            r_skid_f <= sq_fault;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = 32'(r_out_d);
    assign o_m_tuser  = r_out_f;

    // ---------------- assertions ----------------
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dva_vld == dvb_vld)
        else $error("divider lanes out of step");

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid holds a result while output is empty");

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == 32'd0))
        else $error("faulted transfer carries a nonzero distance");

    a_stall_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !i_m_tready) |=> !o_s_tready)
        else $error("input accepted while both output registers full");

endmodule

`default_nettype wire

### rtl/lsmid_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module lsmid_div #(
    parameter int NW  = 18,
    parameter int DVW = 9,
    parameter int QBW = 8,
    parameter int PW  = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire lsmid_pkg::t_flow i_flow,
    input  wire logic [NW-1:0]    i_dividend,
    input  wire logic [DVW-1:0]   i_divisor,
    input  wire logic [PW-1:0]    i_pay,
    output logic                  o_vld,
    output logic [QBW-1:0]        o_quo,
    output logic [NW-1:0]         o_rem,
    output logic [PW-1:0]         o_pay
);

    localparam int CPW = (NW > DVW + QBW) ? NW : DVW + QBW;

    logic [NW-1:0]  st_rem [QBW+1];
    logic [QBW-1:0] st_q   [QBW+1];
    logic [PW-1:0]  st_pay [QBW+1];
    logic           st_vld [QBW+1];

    assign st_rem[0] = i_dividend;
    assign st_q[0]   = '0;
    assign st_pay[0] = i_pay;
    assign st_vld[0] = i_flow.vld;

    for (genvar g = 0; g < QBW; g++) begin : g_stage
        localparam int BI = QBW - 1 - g;
        logic [CPW-1:0] sh;
        logic           take;
        logic [NW-1:0]  r_rem;
        logic [QBW-1:0] r_q;
        logic [PW-1:0]  r_pay;
        logic           r_vld;

        assign sh   = CPW'(i_divisor) << BI;
        assign take = CPW'(st_rem[g]) >= sh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_flow.en) begin
                r_vld <= st_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_flow.en) begin
                r_rem <= take ? NW'(CPW'(st_rem[g]) - sh) : st_rem[g];
                r_q   <= st_q[g] | (take ? (QBW'(1) << BI) : '0);
                r_pay <= st_pay[g];
            end
        end

        assign st_rem[g+1] = r_rem;
        assign st_q[g+1]   = r_q;
        assign st_pay[g+1] = r_pay;
        assign st_vld[g+1] = r_vld;
    end

    assign o_vld = st_vld[QBW];
    assign o_quo = st_q[QBW];
    assign o_rem = st_rem[QBW];
    assign o_pay = st_pay[QBW];

endmodule

`default_nettype wire

### rtl/lsmid_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module lsmid_sqrt #(
    parameter int IW = 59,
    parameter int OW = 30,
    parameter int PW = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire lsmid_pkg::t_flow i_flow,
    input  wire logic [IW-1:0]    i_rad,
    input  wire logic [PW-1:0]    i_pay,
    output logic                  o_vld,
    output logic [OW-1:0]         o_root,
    output logic [PW-1:0]         o_pay
);

    logic [IW-1:0] st_rem [OW+1];
    logic [OW-1:0] st_r   [OW+1];
    logic [PW-1:0] st_pay [OW+1];
    logic          st_vld [OW+1];

    assign st_rem[0] = i_rad;
    assign st_r[0]   = '0;
    assign st_pay[0] = i_pay;
    assign st_vld[0] = i_flow.vld;

    for (genvar g = 0; g < OW; g++) begin : g_stage
        localparam int BI = OW - 1 - g;
        logic [IW:0]   trial;
        logic          take;
        logic [IW-1:0] r_rem;
        logic [OW-1:0] r_r;
        logic [PW-1:0] r_pay;
        logic          r_vld;

        // (r + 2^i)^2 - r^2 = r*2^(i+1) + 2^(2i)
        assign trial = ((IW+1)'(st_r[g]) << (BI + 1)) + ((IW+1)'(1) << (2 * BI));
        assign take  = (IW+1)'(st_rem[g]) >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_flow.en) begin
                r_vld <= st_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_flow.en) begin
                r_rem <= take ? IW'((IW+1)'(st_rem[g]) - trial) : st_rem[g];
                r_r   <= st_r[g] | (take ? (OW'(1) << BI) : '0);
                r_pay <= st_pay[g];
            end
        end

        assign st_rem[g+1] = r_rem;
        assign st_r[g+1]   = r_r;
        assign st_pay[g+1] = r_pay;
        assign st_vld[g+1] = r_vld;
    end

    assign o_vld  = st_vld[OW];
    assign o_root = st_r[OW];
    assign o_pay  = st_pay[OW];

endmodule

`default_nettype wire
